// ===== sv/hrt_pkg.sv =====
// shared types and codes for the http request header tokenizer
// no dependencies; used by the parser, the top level and the checker
package hrt_pkg;

    localparam int MAX_FIELDS_DEF = 32;

    localparam int DATA_W  = 8;
    localparam int CLASS_W = 3;
    localparam int INDEX_W = 5;
    localparam int PHASE_W = 4;

    // special characters
    localparam logic [DATA_W-1:0] CH_LF    = 8'h0A;
    localparam logic [DATA_W-1:0] CH_CR    = 8'h0D;
    localparam logic [DATA_W-1:0] CH_SP    = 8'h20;
    localparam logic [DATA_W-1:0] CH_COLON = 8'h3A;

    // byte classes
    localparam logic [CLASS_W-1:0] CL_METHOD  = 3'd0;
    localparam logic [CLASS_W-1:0] CL_URI     = 3'd1;
    localparam logic [CLASS_W-1:0] CL_VERSION = 3'd2;
    localparam logic [CLASS_W-1:0] CL_KEY     = 3'd3;
    localparam logic [CLASS_W-1:0] CL_VALUE   = 3'd4;
    localparam logic [CLASS_W-1:0] CL_DELIM   = 3'd5;
    localparam logic [CLASS_W-1:0] CL_BODY    = 3'd6;

    // parser phases
    localparam logic [PHASE_W-1:0] PH_METHOD_S = 4'd0;
    localparam logic [PHASE_W-1:0] PH_METHOD   = 4'd1;
    localparam logic [PHASE_W-1:0] PH_URI_S    = 4'd2;
    localparam logic [PHASE_W-1:0] PH_URI      = 4'd3;
    localparam logic [PHASE_W-1:0] PH_VER_S    = 4'd4;
    localparam logic [PHASE_W-1:0] PH_VER      = 4'd5;
    localparam logic [PHASE_W-1:0] PH_RL_LF    = 4'd6;
    localparam logic [PHASE_W-1:0] PH_LINE_S   = 4'd7;
    localparam logic [PHASE_W-1:0] PH_KEY      = 4'd8;
    localparam logic [PHASE_W-1:0] PH_VAL_SP   = 4'd9;
    localparam logic [PHASE_W-1:0] PH_VAL_S    = 4'd10;
    localparam logic [PHASE_W-1:0] PH_VAL      = 4'd11;
    localparam logic [PHASE_W-1:0] PH_VAL_LF   = 4'd12;
    localparam logic [PHASE_W-1:0] PH_END_LF   = 4'd13;
    localparam logic [PHASE_W-1:0] PH_BODY_S   = 4'd14;
    localparam logic [PHASE_W-1:0] PH_BODY     = 4'd15;

    // one tagged byte
    typedef struct packed {
        logic [CLASS_W-1:0] byte_class;
        logic               token_start;
        logic [INDEX_W-1:0] field_index;
        logic               header_done;
        logic               field_overflow;
        logic               malformed;
    } result_t;

endpackage

// ===== sv/http_request_header_tokenizer.sv =====
// an accepted beat is held in the input register, then parsed and moved into the result
// register, which presents it; a held beat waits while the result register is stalled
// one byte per cycle while the result side is not stalled, set by the phase update
// between the input register and the result register
// reset: synchronous, active low; clears both valid flags, the parse phase, the field
// count and the sticky flags; payload registers are not reset
// depends on hrt_pkg and hrt_parser
module http_request_header_tokenizer #(
    parameter int MAX_FIELDS = hrt_pkg::MAX_FIELDS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    // input beats
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [hrt_pkg::DATA_W-1:0]  s_data_byte,
    input  logic                        s_first_byte,
    // result beats
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [hrt_pkg::CLASS_W-1:0] m_byte_class,
    output logic                        m_token_start,
    output logic [hrt_pkg::INDEX_W-1:0] m_field_index,
    output logic                        m_header_done,
    output logic                        m_field_overflow,
    output logic                        m_malformed
);

    // input register stage
    logic                       in_valid_reg, in_valid_next;
    logic [hrt_pkg::DATA_W-1:0] in_data_reg;
    logic                       in_first_reg;

    // result register stage
    logic             out_valid_reg, out_valid_next;
    hrt_pkg::result_t out_res_reg;
    hrt_pkg::result_t step_res;

    logic out_free;   // result register can take a beat this cycle
    logic step;       // held byte is parsed and moves into the result register
    logic s_take;

    assign out_free = !out_valid_reg || m_ready;
    assign step     = in_valid_reg && out_free;
    // input side keeps flowing while the result register drains
    assign s_ready  = !in_valid_reg || step;
    assign s_take   = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_valid_next = 1'b1;
        end else if (step) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_data_reg  <= s_data_byte;
            in_first_reg <= s_first_byte;
        end
        if (step) begin
            out_res_reg <= step_res;
        end
    end

    // phase machine: classifies the held byte and advances only on step
    hrt_parser #(
        .MAX_FIELDS (MAX_FIELDS)
    ) u_parser (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .data_byte  (in_data_reg),
        .first_byte (in_first_reg),
        .result     (step_res)
    );

    assign m_valid          = out_valid_reg;
    assign m_byte_class     = out_res_reg.byte_class;
    assign m_token_start    = out_res_reg.token_start;
    assign m_field_index    = out_res_reg.field_index;
    assign m_header_done    = out_res_reg.header_done;
    assign m_field_overflow = out_res_reg.field_overflow;
    assign m_malformed      = out_res_reg.malformed;

endmodule

// ===== sv/hrt_parser.sv =====
// phase machine, field counter and sticky flags of the tokenizer
// depends on hrt_pkg
module hrt_parser #(
    parameter int MAX_FIELDS = hrt_pkg::MAX_FIELDS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic [hrt_pkg::DATA_W-1:0] data_byte,
    input  logic                       first_byte,
    output hrt_pkg::result_t           result
);

    localparam int CNT_W = $clog2(MAX_FIELDS + 1);
    localparam int EXT_W = (CNT_W > hrt_pkg::INDEX_W) ? CNT_W : hrt_pkg::INDEX_W;

    logic [hrt_pkg::PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic                        ovf_reg, ovf_next;
    logic                        mal_reg, mal_next;

    logic [hrt_pkg::PHASE_W-1:0] ph;
    logic [CNT_W-1:0]            cnt_base;
    logic                        ovf_base;
    logic                        start_fld;
    logic [hrt_pkg::CLASS_W-1:0] cls;
    logic                        tstart;
    logic                        done;
    logic [EXT_W-1:0]            cnt_ext;
    logic [EXT_W-1:0]            idx_ext;

    always_comb begin
        // a new request clears everything before the byte is parsed
        ph        = first_byte ? hrt_pkg::PH_METHOD_S : phase_reg;
        cnt_base  = first_byte ? '0 : cnt_reg;
        ovf_base  = first_byte ? 1'b0 : ovf_reg;
        mal_next  = first_byte ? 1'b0 : mal_reg;
        cls       = hrt_pkg::CL_DELIM;
        tstart    = 1'b0;
        done      = 1'b0;
        start_fld = 1'b0;

        // cr not followed by lf
        if ((ph inside {hrt_pkg::PH_RL_LF, hrt_pkg::PH_VAL_LF, hrt_pkg::PH_END_LF}) &&
            data_byte != hrt_pkg::CH_LF) begin
            mal_next = 1'b1;
            ph       = hrt_pkg::PH_LINE_S;
        end

        phase_next = ph;
        case (ph)
            hrt_pkg::PH_METHOD_S, hrt_pkg::PH_METHOD: begin
                if (data_byte == hrt_pkg::CH_SP) begin
                    phase_next = hrt_pkg::PH_URI_S;
                end else if (data_byte == hrt_pkg::CH_CR) begin
                    phase_next = hrt_pkg::PH_RL_LF;
                end else begin
                    cls        = hrt_pkg::CL_METHOD;
                    tstart     = (ph == hrt_pkg::PH_METHOD_S);
                    phase_next = hrt_pkg::PH_METHOD;
                end
            end
            hrt_pkg::PH_URI_S, hrt_pkg::PH_URI: begin
                if (data_byte == hrt_pkg::CH_SP) begin
                    phase_next = hrt_pkg::PH_VER_S;
                end else if (data_byte == hrt_pkg::CH_CR) begin
                    phase_next = hrt_pkg::PH_RL_LF;
                end else begin
                    cls        = hrt_pkg::CL_URI;
                    tstart     = (ph == hrt_pkg::PH_URI_S);
                    phase_next = hrt_pkg::PH_URI;
                end
            end
            hrt_pkg::PH_VER_S, hrt_pkg::PH_VER: begin
                if (data_byte == hrt_pkg::CH_SP) begin
                    phase_next = hrt_pkg::PH_VER_S;
                end else if (data_byte == hrt_pkg::CH_CR) begin
                    phase_next = hrt_pkg::PH_RL_LF;
                end else begin
                    cls        = hrt_pkg::CL_VERSION;
                    tstart     = (ph == hrt_pkg::PH_VER_S);
                    phase_next = hrt_pkg::PH_VER;
                end
            end
            hrt_pkg::PH_RL_LF, hrt_pkg::PH_VAL_LF: begin
                phase_next = hrt_pkg::PH_LINE_S;
            end
            hrt_pkg::PH_END_LF: begin
                done       = 1'b1;
                phase_next = hrt_pkg::PH_BODY_S;
            end
            hrt_pkg::PH_LINE_S: begin
                if (data_byte == hrt_pkg::CH_CR) begin
                    phase_next = hrt_pkg::PH_END_LF;
                end else if (data_byte == hrt_pkg::CH_COLON) begin
                    start_fld  = 1'b1;
                    phase_next = hrt_pkg::PH_VAL_SP;
                end else begin
                    start_fld  = 1'b1;
                    cls        = hrt_pkg::CL_KEY;
                    tstart     = 1'b1;
                    phase_next = hrt_pkg::PH_KEY;
                end
            end
            hrt_pkg::PH_KEY: begin
                if (data_byte == hrt_pkg::CH_COLON) begin
                    phase_next = hrt_pkg::PH_VAL_SP;
                end else if (data_byte == hrt_pkg::CH_CR) begin
                    mal_next   = 1'b1;
                    phase_next = hrt_pkg::PH_VAL_LF;
                end else begin
                    cls = hrt_pkg::CL_KEY;
                end
            end
            hrt_pkg::PH_VAL_SP, hrt_pkg::PH_VAL_S, hrt_pkg::PH_VAL: begin
                if (data_byte == hrt_pkg::CH_CR) begin
                    phase_next = hrt_pkg::PH_VAL_LF;
                end else if (data_byte == hrt_pkg::CH_SP && ph == hrt_pkg::PH_VAL_SP) begin
                    phase_next = hrt_pkg::PH_VAL_S;
                end else begin
                    cls        = hrt_pkg::CL_VALUE;
                    tstart     = (ph != hrt_pkg::PH_VAL);
                    phase_next = hrt_pkg::PH_VAL;
                end
            end
            default: begin
                cls        = hrt_pkg::CL_BODY;
                tstart     = (ph == hrt_pkg::PH_BODY_S);
                phase_next = hrt_pkg::PH_BODY;
            end
        endcase

        // saturating field count
        cnt_next = cnt_base;
        ovf_next = ovf_base;
        if (start_fld) begin
            if (cnt_base < CNT_W'(MAX_FIELDS)) begin
                cnt_next = cnt_base + CNT_W'(1);
            end else begin
                ovf_next = 1'b1;
            end
        end

        cnt_ext = EXT_W'(cnt_next);
        idx_ext = (cnt_ext == '0) ? '0 : cnt_ext - EXT_W'(1);

        result.byte_class     = cls;
        result.token_start    = tstart;
        result.field_index    = idx_ext[hrt_pkg::INDEX_W-1:0];
        result.header_done    = done;
        result.field_overflow = ovf_next;
        result.malformed      = mal_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= hrt_pkg::PH_METHOD_S;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            mal_reg   <= 1'b0;
        end else if (step) begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            mal_reg   <= mal_next;
        end
    end

endmodule

// ===== sv/hrt_checker.sv =====
// port-level checks for the http request header tokenizer, bound to the top level
// depends on hrt_pkg
module hrt_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_ready,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [hrt_pkg::CLASS_W-1:0] m_byte_class,
    input logic                        m_token_start,
    input logic [hrt_pkg::INDEX_W-1:0] m_field_index,
    input logic                        m_header_done,
    input logic                        m_field_overflow,
    input logic                        m_malformed
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_byte_class) && $stable(m_token_start)
            && $stable(m_field_index) && $stable(m_header_done)
            && $stable(m_field_overflow) && $stable(m_malformed))
        else $error("result beat changed while stalled");

    // nothing comes out straight after reset
    a_reset_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    // delimiters never open a token
    a_delim_no_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_token_start |-> m_byte_class != hrt_pkg::CL_DELIM)
        else $error("token start on a delimiter");

    // the end of the header is a delimiter byte
    a_done_delim: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_header_done |-> m_byte_class == hrt_pkg::CL_DELIM && !m_token_start)
        else $error("header end not tagged as delimiter");

    // input is ready whenever a result beat drains
    a_ready_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready |-> s_ready)
        else $error("input blocked while result drains");

endmodule

bind http_request_header_tokenizer hrt_checker u_hrt_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_byte_class     (m_byte_class),
    .m_token_start    (m_token_start),
    .m_field_index    (m_field_index),
    .m_header_done    (m_header_done),
    .m_field_overflow (m_field_overflow),
    .m_malformed      (m_malformed)
);
